>>> hw/rtl/stuffed_frame_builder_defines.svh
// assertion macros shared by the frame builder rtl
// no dependencies; included by modules that carry assertions
`ifndef STUFFED_FRAME_BUILDER_DEFINES_SVH
`define STUFFED_FRAME_BUILDER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, disabled while reset is asserted
`define SFB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sfb assertion failed");
// checked property, also during reset
`define SFB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("sfb assertion failed");
`else
`define SFB_ASSERT(lbl, prop)
`define SFB_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> hw/rtl/sfb_pkg.sv
// types, codes and constants of the stuffed frame builder
// no dependencies; imported by every module of the block
package sfb_pkg;

    localparam int ByteW  = 8;
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_FLAG        = 3'd0,
        CFG_ESCAPE      = 3'd1,
        CFG_FLAG_HIDE   = 3'd2,
        CFG_ESCAPE_HIDE = 3'd3,
        CFG_ADDRESS     = 3'd4
    } cfg_index_t;

    localparam int CfgIdxW = $bits(cfg_index_t);

    localparam logic [ByteW-1:0] FlagReset       = 8'd126;
    localparam logic [ByteW-1:0] EscapeReset     = 8'd125;
    localparam logic [ByteW-1:0] FlagHideReset   = 8'd94;
    localparam logic [ByteW-1:0] EscapeHideReset = 8'd93;
    localparam logic [ByteW-1:0] AddressReset    = 8'd3;

    // one unit of the frame, in line order
    typedef enum logic [2:0] {
        STEP_OPEN,
        STEP_ADDR,
        STEP_CTRL,
        STEP_BCC1,
        STEP_DATA,
        STEP_BCC2,
        STEP_CLOSE
    } step_t;

    typedef struct packed {
        logic [ByteW-1:0] payload_byte;
        logic             is_first;
        logic             is_last;
        logic [ByteW-1:0] control_byte;
    } item_t;

    typedef struct packed {
        logic [ByteW-1:0] line_byte;
        logic             run_last;
        logic             frame_done;
    } result_t;

    typedef struct packed {
        logic [ByteW-1:0] flag_byte;
        logic [ByteW-1:0] escape_byte;
        logic [ByteW-1:0] flag_alt_byte;
        logic [ByteW-1:0] escape_hide_byte;
        logic [ByteW-1:0] address_byte;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [ByteW-1:0] data;
        logic [ByteW-1:0] ctrl;
        logic [ByteW-1:0] bcc2;
        logic             hdr;
        logic             last;
    } job_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

endpackage

>>> hw/rtl/sfb_front.sv
// front end: accepts items, decides header and trailer, tracks bcc2
// depends on sfb_pkg and the assertion header
`include "stuffed_frame_builder_defines.svh"

module sfb_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfb_pkg::item_t item,
    input  sfb_pkg::q_stat_t q_stat,
    output logic           job_push,
    output sfb_pkg::job_t  job
);
    import sfb_pkg::*;

    logic [ByteW-1:0] check_reg, check_next;
    logic             inside_reg, inside_next;
    logic             hdr;
    logic [ByteW-1:0] new_check;

    assign job_push  = push && !q_stat.full;
    assign hdr       = item.is_first || !inside_reg;
    assign new_check = hdr ? item.payload_byte : (check_reg ^ item.payload_byte);

    always_comb
    begin
        job.data = item.payload_byte;
        job.ctrl = item.control_byte;
        job.bcc2 = new_check;
        job.hdr  = hdr;
        job.last = item.is_last;
    end

    always_comb
    begin
        check_next  = check_reg;
        inside_next = inside_reg;
        if (job_push)
        begin
            check_next  = item.is_last ? '0 : new_check;
            inside_next = !item.is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_reg  <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            check_reg  <= check_next;
            inside_reg <= inside_next;
        end
    end

    // a closed frame leaves a cleared check behind
    `SFB_ASSERT(a_check_clear_idle, !inside_reg |-> check_reg == '0)

endmodule

>>> hw/rtl/sfb_queue.sv
// two-entry job queue between front and back
// depends on sfb_pkg and the assertion header
`include "stuffed_frame_builder_defines.svh"

module sfb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sfb_pkg::job_t    wdata,
    input  logic             pop,
    output sfb_pkg::job_t    rdata,
    output sfb_pkg::q_stat_t stat
);
    import sfb_pkg::*;

    job_t             mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == QCntW'(QDepth));
    assign stat.avail = (count_reg != '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.avail;
    assign rdata      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SFB_ASSERT(a_count_bounded, count_reg <= QCntW'(QDepth))
    `SFB_ASSERT(a_ptrs_match_count,
        (count_reg == '0 || count_reg == QCntW'(QDepth)) |-> wr_ptr_reg == rd_ptr_reg)

endmodule

>>> hw/rtl/sfb_back.sv
// back end: walks each job's units, stuffs them, fills the result register
// depends on sfb_pkg and the assertion header
`include "stuffed_frame_builder_defines.svh"

module sfb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sfb_pkg::cfg_t    cfg,
    input  sfb_pkg::job_t    job,
    input  sfb_pkg::q_stat_t q_stat,
    output logic             job_pop,
    output logic             empty,
    input  logic             pop,
    output sfb_pkg::result_t result
);
    import sfb_pkg::*;

    step_t            step_reg, step_next, cur_step, after_step;
    logic             active_reg, active_next;
    logic             half_reg, half_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;
    logic [ByteW-1:0] unit_byte, line_byte;
    logic             stuffable, is_flag, is_esc, needs_pair;
    logic             unit_end, job_end, advance;

    assign cur_step = active_reg ? step_reg : (job.hdr ? STEP_OPEN : STEP_DATA);
    assign advance  = q_stat.avail && (!out_valid_reg || pop);

    always_comb
    begin
        unit_byte  = job.data;
        stuffable  = 1'b1;
        after_step = STEP_OPEN;
        unique case (cur_step)
            STEP_OPEN:
            begin
                unit_byte  = cfg.flag_byte;
                stuffable  = 1'b0;
                after_step = STEP_ADDR;
            end
            STEP_ADDR:
            begin
                unit_byte  = cfg.address_byte;
                after_step = STEP_CTRL;
            end
            STEP_CTRL:
            begin
                unit_byte  = job.ctrl;
                after_step = STEP_BCC1;
            end
            STEP_BCC1:
            begin
                unit_byte  = cfg.address_byte ^ job.ctrl;
                after_step = STEP_DATA;
            end
            STEP_DATA:
            begin
                unit_byte  = job.data;
                after_step = STEP_BCC2;
            end
            STEP_BCC2:
            begin
                unit_byte  = job.bcc2;
                after_step = STEP_CLOSE;
            end
            STEP_CLOSE:
            begin
                unit_byte  = cfg.flag_byte;
                stuffable  = 1'b0;
                after_step = STEP_OPEN;
            end
            default:
            begin
                unit_byte  = job.data;
                after_step = STEP_OPEN;
            end
        endcase
    end

    always_comb
    begin
        is_flag    = (unit_byte == cfg.flag_byte);
        is_esc     = (unit_byte == cfg.escape_byte);
        needs_pair = stuffable && (is_flag || is_esc);
        unit_end   = !needs_pair || half_reg;
        job_end    = unit_end &&
                     ((cur_step == STEP_DATA && !job.last) || cur_step == STEP_CLOSE);
        if (needs_pair && !half_reg)
        begin
            line_byte = cfg.escape_byte;
        end
        else if (needs_pair)
        begin
            line_byte = is_flag ? cfg.flag_alt_byte : cfg.escape_hide_byte;
        end
        else
        begin
            line_byte = unit_byte;
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        active_next    = active_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        job_pop        = 1'b0;
        if (advance)
        begin
            out_valid_next      = 1'b1;
            out_next.line_byte  = line_byte;
            out_next.run_last   = job_end;
            out_next.frame_done = (cur_step == STEP_CLOSE);
            if (!unit_end)
            begin
                half_next   = 1'b1;
                active_next = 1'b1;
                step_next   = cur_step;
            end
            else if (job_end)
            begin
                half_next   = 1'b0;
                active_next = 1'b0;
                job_pop     = 1'b1;
            end
            else
            begin
                half_next   = 1'b0;
                active_next = 1'b1;
                step_next   = after_step;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_OPEN;
            active_reg    <= 1'b0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            active_reg    <= active_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    `SFB_ASSERT(a_half_inside_job, half_reg |-> active_reg)
    `SFB_ASSERT(a_done_ends_run, out_valid_reg && out_reg.frame_done |-> out_reg.run_last)

endmodule

>>> hw/rtl/stuffed_frame_builder.sv
// top level of the byte-stuffed frame builder with xor block checks
// depends on sfb_pkg, sfb_front, sfb_queue and sfb_back
//
// usage:
//   input side is a queue write port: drive item and raise push; the item
//   transfers at a clock edge with push high and full low
//   result side is a queue read port: while empty is low, result holds the
//   oldest line byte; it transfers at a clock edge with pop high
//   configuration: wr_en, wr_index, wr_data write one register per edge;
//   indexes beyond the address register are dropped; write only when idle
// timing:
//   each item yields 1 to 12 line bytes (header, stuffed payload, bcc2,
//   closing flag); the result register delivers one line byte per cycle
//   while pop is high and a job waits in the queue
//   first byte of an item is held in the job queue, then in the result register
//   a two-entry job queue sits between front and back, so new items are
//   taken while earlier ones are still being stuffed out
// reset: registers return to 0x7e/0x7d/0x5e/0x5d/0x03, no frame open,
//   check cleared, queue and result register empty
// stalls: with pop low the result register holds its byte; the queue
//   fills and full rises after two waiting items
module stuffed_frame_builder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  sfb_pkg::item_t                item,
    output logic                          empty,
    input  logic                          pop,
    output sfb_pkg::result_t              result,
    input  logic                          wr_en,
    input  logic [sfb_pkg::CfgIdxW-1:0]   wr_index,
    input  logic [sfb_pkg::ByteW-1:0]     wr_data
);
    import sfb_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    q_stat_t q_stat;
    job_t    front_job, head_job;
    logic    job_push, job_pop;

    // configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                CFG_FLAG:        cfg_next.flag_byte        = wr_data;
                CFG_ESCAPE:      cfg_next.escape_byte      = wr_data;
                CFG_FLAG_HIDE:   cfg_next.flag_alt_byte    = wr_data;
                CFG_ESCAPE_HIDE: cfg_next.escape_hide_byte = wr_data;
                CFG_ADDRESS:     cfg_next.address_byte     = wr_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte        <= FlagReset;
            cfg_reg.escape_byte      <= EscapeReset;
            cfg_reg.flag_alt_byte    <= FlagHideReset;
            cfg_reg.escape_hide_byte <= EscapeHideReset;
            cfg_reg.address_byte     <= AddressReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify the item and fold it into the payload check
    sfb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .q_stat   (q_stat),
        .job_push (job_push),
        .job      (front_job)
    );

    // decoupling queue
    sfb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (front_job),
        .pop   (job_pop),
        .rdata (head_job),
        .stat  (q_stat)
    );

    // back: emit stuffed line bytes
    sfb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .job     (head_job),
        .q_stat  (q_stat),
        .job_pop (job_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    assign full = q_stat.full;

endmodule

>>> test/stuffed_frame_builder_tb.sv
// self-checking testbench of the stuffed frame builder
// depends on sfb_pkg and the stuffed_frame_builder rtl; needs no other files
// a scoreboard class predicts every line byte; plain tasks drive the block
module stuffed_frame_builder_tb;

    import sfb_pkg::*;

    // predicts the line bytes of each accepted item and checks them in order
    class frame_tracker;
        cfg_t             regs;
        logic [ByteW-1:0] payload_xor;
        bit               frame_open;
        result_t          due[$];
        int               errors;
        int               items_seen;
        int               lines_seen;
        int               frames_closed;
        int               widest_run;

        function new();
            regs        = '{FlagReset, EscapeReset, FlagHideReset, EscapeHideReset,
                            AddressReset};
            payload_xor = '0;
            frame_open  = 1'b0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
            case (idx)
                CFG_FLAG:        regs.flag_byte        = val;
                CFG_ESCAPE:      regs.escape_byte      = val;
                CFG_FLAG_HIDE:   regs.flag_alt_byte    = val;
                CFG_ESCAPE_HIDE: regs.escape_hide_byte = val;
                CFG_ADDRESS:     regs.address_byte     = val;
                default:         ;
            endcase
        endfunction

        function void put_line(logic [ByteW-1:0] b, bit done);
            result_t r;
            r.line_byte  = b;
            r.run_last   = 1'b0;
            r.frame_done = done;
            due.push_back(r);
        endfunction

        // flag wins over escape when the two registers are equal
        function void put_stuffed(logic [ByteW-1:0] b);
            if (b == regs.flag_byte)
            begin
                put_line(regs.escape_byte, 1'b0);
                put_line(regs.flag_alt_byte, 1'b0);
            end
            else if (b == regs.escape_byte)
            begin
                put_line(regs.escape_byte, 1'b0);
                put_line(regs.escape_hide_byte, 1'b0);
            end
            else
            begin
                put_line(b, 1'b0);
            end
        endfunction

        function void note_item(item_t it);
            int before_cnt;
            before_cnt = due.size();
            items_seen++;
            // header on an explicit start, or implicitly when no frame is open
            if (it.is_first || !frame_open)
            begin
                put_line(regs.flag_byte, 1'b0);
                put_stuffed(regs.address_byte);
                put_stuffed(it.control_byte);
                put_stuffed(regs.address_byte ^ it.control_byte);
                payload_xor = '0;
                frame_open  = 1'b1;
            end
            put_stuffed(it.payload_byte);
            payload_xor ^= it.payload_byte;
            if (it.is_last)
            begin
                put_stuffed(payload_xor);
                put_line(regs.flag_byte, 1'b1);
                payload_xor = '0;
                frame_open  = 1'b0;
            end
            due[due.size()-1].run_last = 1'b1;
            if (due.size() - before_cnt > widest_run)
                widest_run = due.size() - before_cnt;
        endfunction

        function void check_line(result_t got);
            result_t want;
            lines_seen++;
            if (got.frame_done)
                frames_closed++;
            if (due.size() == 0)
            begin
                $error("line byte %02h arrived with nothing expected", got.line_byte);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.line_byte !== want.line_byte)
            begin
                $error("line_byte: expected %02h, got %02h", want.line_byte, got.line_byte);
                errors++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                errors++;
            end
            if (got.frame_done !== want.frame_done)
            begin
                $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
                errors++;
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 push     = 1'b0;
    logic                 full;
    item_t                item     = '0;
    logic                 empty;
    logic                 pop      = 1'b0;
    result_t              result;
    logic                 wr_en    = 1'b0;
    logic [CfgIdxW-1:0]   wr_index = '0;
    logic [ByteW-1:0]     wr_data  = '0;

    frame_tracker tracker = new();

    // when set, neither side idles
    bit steady = 1'b0;
    int settings_used = 0;

    stuffed_frame_builder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // input transfers go to the predictor, sampled with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            tracker.note_item(item);
    end

    // result transfers are checked, then pop is redrawn for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            tracker.check_line(result);
        pop <= steady || ($urandom_range(99) >= 21);
    end

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("FAIL stuffed_frame_builder");
        $finish;
    end

    function automatic item_t make_item(logic [ByteW-1:0] data, logic first, logic last,
                                        logic [ByteW-1:0] ctrl);
        item_t it;
        it.payload_byte = data;
        it.is_first     = first;
        it.is_last      = last;
        it.control_byte = ctrl;
        return it;
    endfunction

    // random byte that hits the register values much more often than chance
    function automatic logic [ByteW-1:0] pick_byte();
        case ($urandom_range(11))
            0:       return tracker.regs.flag_byte;
            1:       return tracker.regs.escape_byte;
            2:       return tracker.regs.flag_alt_byte;
            3:       return tracker.regs.escape_hide_byte;
            4:       return tracker.regs.address_byte;
            // as a control byte this makes bcc1 land on the flag
            5:       return tracker.regs.address_byte ^ tracker.regs.flag_byte;
            6:       return tracker.regs.address_byte ^ tracker.regs.escape_byte;
            default: return ByteW'($urandom_range(255));
        endcase
    endfunction

    // offers one item, with random gaps before it, and returns after its transfer
    task automatic send_item(input item_t it);
        while (!steady && $urandom_range(99) < 21)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
    endtask

    // holds the sender off until every predicted line byte has been seen
    task automatic drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (tracker.due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        tracker.write_reg(idx, val);
        @(posedge clk);
    endtask

    // writes every register, plus one index past the last that must be dropped
    task automatic program_regs(input logic [ByteW-1:0] flag, input logic [ByteW-1:0] esc,
                                input logic [ByteW-1:0] flag_hide,
                                input logic [ByteW-1:0] esc_hide,
                                input logic [ByteW-1:0] addr);
        logic [CfgIdxW-1:0] stray;
        stray = CfgIdxW'(CFG_ADDRESS) + CfgIdxW'($urandom_range(3, 1));
        write_reg(CFG_FLAG, flag);
        write_reg(CFG_ESCAPE, esc);
        write_reg(CFG_FLAG_HIDE, flag_hide);
        write_reg(CFG_ESCAPE_HIDE, esc_hide);
        write_reg(CFG_ADDRESS, addr);
        write_reg(stray, ByteW'($urandom_range(255)));
        wr_en <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // mostly well formed frames, some left open, some loose items
    task automatic run_random(input int count);
        int sent;
        int len;
        int kind;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
            if (kind < 88)
            begin
                // frames below 80 close normally, the rest are left open
                for (int k = 0; k < len; k++)
                    send_item(make_item(pick_byte(), k == 0,
                                        (kind < 80) && (k == len - 1), pick_byte()));
                sent += len;
            end
            else
            begin
                send_item(make_item(pick_byte(), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), pick_byte()));
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset register values
        // single-byte frame: flag payload, bcc1 that equals the flag
        send_item(make_item(8'h7E, 1'b1, 1'b1, 8'h7D));
        // a frame walking through escape, zero, all-ones and both hide bytes
        send_item(make_item(8'h7D, 1'b1, 1'b0, 8'h00));
        send_item(make_item(8'h00, 1'b0, 1'b0, 8'hFF));
        send_item(make_item(8'hFF, 1'b0, 1'b0, 8'hAA));
        send_item(make_item(8'h5E, 1'b0, 1'b0, 8'h55));
        send_item(make_item(8'h5D, 1'b0, 1'b1, 8'h00));
        // item while idle without a start opens a frame on its own
        send_item(make_item(8'h11, 1'b0, 1'b0, 8'h7E));
        // a start in the middle of an open frame abandons it
        send_item(make_item(8'h22, 1'b1, 1'b0, 8'hFF));
        send_item(make_item(8'h7E, 1'b0, 1'b1, 8'h00));
        // implicit open and close on the same item
        send_item(make_item(8'h80, 1'b0, 1'b1, 8'h01));
        // control equal to the address gives a zero bcc1
        send_item(make_item(8'h01, 1'b1, 1'b0, 8'h03));
        send_item(make_item(8'h7C, 1'b0, 1'b1, 8'h7D));
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: program_regs(FlagReset, EscapeReset, FlagHideReset, EscapeHideReset,
                                AddressReset);
                // hide bytes equal to flag and escape must go out unstuffed
                1: program_regs(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
                2: program_regs(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
                3:
                begin
                    wr_data <= ByteW'($urandom_range(255));
                    @(posedge clk);
                    program_regs(wr_data, wr_data, ByteW'($urandom_range(255)),
                                 ByteW'($urandom_range(255)), ByteW'($urandom_range(255)));
                end
                default: program_regs(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                                      ByteW'($urandom_range(255)),
                                      ByteW'($urandom_range(255)),
                                      ByteW'($urandom_range(255)));
            endcase

            if (phase == 1)
            begin
                // every field stuffed: the longest possible run of line bytes
                send_item(make_item(8'h00, 1'b1, 1'b1, 8'hFF));
            end
            if (phase == 3)
            begin
                // flag and escape equal: the shared value is handled as a flag
                send_item(make_item(tracker.regs.flag_byte, 1'b1, 1'b0,
                                    tracker.regs.flag_byte));
                send_item(make_item(tracker.regs.escape_hide_byte, 1'b0, 1'b1, 8'h00));
            end

            // one phase with no idling on either side
            steady = (phase == 2);
            run_random(50);
            drain();
            steady = 1'b0;
        end

        repeat (20) @(posedge clk);
        $display("run covered %0d items and %0d line bytes in %0d closed frames,",
                 tracker.items_seen, tracker.lines_seen, tracker.frames_closed);
        $display("up to %0d line bytes per item, over %0d register settings",
                 tracker.widest_run, settings_used + 1);
        if (tracker.errors == 0 && tracker.due.size() == 0)
            $display("PASS stuffed_frame_builder");
        else
            $display("FAIL stuffed_frame_builder");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sfb_pkg.sv
hw/rtl/sfb_front.sv
hw/rtl/sfb_queue.sv
hw/rtl/sfb_back.sv
hw/rtl/stuffed_frame_builder.sv
test/stuffed_frame_builder_tb.sv
